// ===== rtl/core/tble_pkg.sv =====
// Shared types and constants for the text box layout engine.
package tble_pkg;

  localparam int unsigned CoordW = 16;
  localparam int unsigned FontW  = 7;
  localparam int unsigned ByteW  = 8;
  localparam int unsigned KindW  = 2;
  localparam int unsigned CfgIdxW = 3;

  // Draw command kinds
  localparam logic [KindW-1:0] KIND_HALF = 2'd0;
  localparam logic [KindW-1:0] KIND_DBL  = 2'd1;
  localparam logic [KindW-1:0] KIND_END  = 2'd2;
  localparam logic [KindW-1:0] KIND_FULL = 2'd3;

  // Configuration register indexes
  localparam logic [CfgIdxW-1:0] REG_ORIGIN_X   = 3'd0;
  localparam logic [CfgIdxW-1:0] REG_ORIGIN_Y   = 3'd1;
  localparam logic [CfgIdxW-1:0] REG_BOX_WIDTH  = 3'd2;
  localparam logic [CfgIdxW-1:0] REG_BOX_HEIGHT = 3'd3;
  localparam logic [CfgIdxW-1:0] REG_FONT_SIZE  = 3'd4;
  localparam logic [CfgIdxW-1:0] REG_DRAW_MODE  = 3'd5;
  localparam logic [CfgIdxW-1:0] REG_TEXT_COLOR = 3'd6;

  // Special bytes
  localparam logic [ByteW-1:0] BYTE_END  = 8'h00;
  localparam logic [ByteW-1:0] BYTE_CR   = 8'd13;
  localparam logic [ByteW-1:0] LEAD_MIN  = 8'h80;

  // Reset values of the box geometry
  localparam logic [CoordW-1:0] BOX_WIDTH_RST  = 16'd240;
  localparam logic [CoordW-1:0] BOX_HEIGHT_RST = 16'd320;
  localparam logic [FontW-1:0]  FONT_SIZE_RST  = 7'd16;

  // Box geometry handed to the placement logic
  typedef struct packed {
    logic [CoordW-1:0] origin_x;
    logic [CoordW-1:0] origin_y;
    logic [CoordW-1:0] box_width;
    logic [CoordW-1:0] box_height;
    logic [FontW-1:0]  font_size;
  } geom_t;

  // Cursor after the wrap test, and the height verdict
  typedef struct packed {
    logic [CoordW-1:0] x;
    logic [CoordW-1:0] y;
    logic              full;
  } place_t;

endpackage

// ===== rtl/core/tble_place.sv =====
// Wrap and box-height test for one glyph at the current cursor.
module tble_place (
  input  tble_pkg::geom_t                   geom,
  input  logic [tble_pkg::CoordW-1:0]       cursor_x,
  input  logic [tble_pkg::CoordW-1:0]       cursor_y,
  input  logic [tble_pkg::FontW-1:0]        glyph_w,
  output tble_pkg::place_t                  place
);

  localparam int unsigned ExtW = tble_pkg::CoordW + 2;

  logic signed [ExtW-1:0] right_lim;
  logic signed [ExtW-1:0] bottom_lim;
  logic signed [ExtW-1:0] cx_ext;
  logic signed [ExtW-1:0] cy_ext;
  logic                   wrap;
  logic [tble_pkg::CoordW-1:0] y_wrapped;

  // Bounds without wrap-around, signed so a tiny box yields a negative limit
  assign right_lim = $signed({2'b00, geom.origin_x}) + $signed({2'b00, geom.box_width})
                   - $signed({{(ExtW-tble_pkg::FontW){1'b0}}, glyph_w});
  assign bottom_lim = $signed({2'b00, geom.origin_y}) + $signed({2'b00, geom.box_height})
                    - $signed({{(ExtW-tble_pkg::FontW){1'b0}}, geom.font_size});

  assign cx_ext = $signed({2'b00, cursor_x});
  assign wrap   = cx_ext > right_lim;

  // Cursor registers wrap modulo 2^16 when advanced
  assign y_wrapped = wrap ? cursor_y + {{(tble_pkg::CoordW-tble_pkg::FontW){1'b0}},
                                        geom.font_size}
                          : cursor_y;
  assign cy_ext = $signed({2'b00, y_wrapped});

  assign place.x    = wrap ? geom.origin_x : cursor_x;
  assign place.y    = y_wrapped;
  assign place.full = cy_ext > bottom_lim;

endmodule

// ===== rtl/core/text_box_layout_engine.sv =====
// Top level of the text box layout engine: byte decode, cursor state, result register.
//
//  Channel  Direction  Handshake           Payload
//  in       input      in_valid/in_ready   in_byte_in[7:0]
//  out      output     out_valid/out_ready out_cmd_kind, out_glyph_x/y, out_glyph_code
//  cfg      input      cfg_valid/cfg_ready cfg_index[2:0], cfg_data[15:0]
//
// Decode, the wrap/height test and the cursor update sit between the cursor
// registers and the result register, so one byte is accepted per clock while
// in_ready is high. A draw command appears on out the cycle after
// its byte's transaction. Bytes that yield no command (lead bytes, carriage
// return, skipped bytes, bytes after the box is full) update state only.
// in_ready drops only while the result register is full and out_ready is
// low; a pending command is then held unchanged. cfg_ready is always high.
// Synchronous active-low reset restores the register defaults, puts the
// cursor at the origin and clears the pending lead, skip and full flags.
module text_box_layout_engine (
  input  logic                            clk,
  input  logic                            rst_n,

  input  logic                            in_valid,
  output logic                            in_ready,
  input  logic [tble_pkg::ByteW-1:0]      in_byte_in,

  output logic                            out_valid,
  input  logic                            out_ready,
  output logic [tble_pkg::KindW-1:0]      out_cmd_kind,
  output logic [tble_pkg::CoordW-1:0]     out_glyph_x,
  output logic [tble_pkg::CoordW-1:0]     out_glyph_y,
  output logic [tble_pkg::CoordW-1:0]     out_glyph_code,

  input  logic                            cfg_valid,
  output logic                            cfg_ready,
  input  logic [tble_pkg::CfgIdxW-1:0]    cfg_index,
  input  logic [tble_pkg::CoordW-1:0]     cfg_data
);

  // Configuration registers. Draw mode and text color only feed pixel
  // drawing, which lives downstream, so their writes are accepted and dropped.
  tble_pkg::geom_t geom_r;

  // Layout state
  logic [tble_pkg::CoordW-1:0] cursor_x_r, cursor_x_nxt;
  logic [tble_pkg::CoordW-1:0] cursor_y_r, cursor_y_nxt;
  logic [tble_pkg::ByteW-1:0]  lead_byte_r, lead_byte_nxt;
  logic                        lead_pending_r, lead_pending_nxt;
  logic                        skip_next_r, skip_next_nxt;
  logic                        box_full_r, box_full_nxt;

  // Result register
  logic                        out_valid_r;
  logic [tble_pkg::KindW-1:0]  out_kind_r;
  logic [tble_pkg::CoordW-1:0] out_x_r;
  logic [tble_pkg::CoordW-1:0] out_y_r;
  logic [tble_pkg::CoordW-1:0] out_code_r;

  // Command built from the byte in flight
  logic                        emit;
  logic [tble_pkg::KindW-1:0]  emit_kind;
  logic [tble_pkg::CoordW-1:0] emit_x;
  logic [tble_pkg::CoordW-1:0] emit_y;
  logic [tble_pkg::CoordW-1:0] emit_code;

  logic                        in_fire;
  logic                        cfg_fire;
  logic [tble_pkg::FontW-1:0]  half_w;
  logic [tble_pkg::FontW-1:0]  glyph_w;
  logic [tble_pkg::CoordW-1:0] fs_ext;
  logic [tble_pkg::CoordW-1:0] half_ext;
  tble_pkg::place_t            place;

  assign cfg_ready = 1'b1;
  assign cfg_fire  = cfg_valid & cfg_ready;

  // Accept a new byte whenever the result register is free or draining
  assign in_ready = ~out_valid_r | out_ready;
  assign in_fire  = in_valid & in_ready;

  assign half_w   = geom_r.font_size >> 1;
  // A trail byte places a full-width glyph, anything else a half-width one
  assign glyph_w  = lead_pending_r ? geom_r.font_size : half_w;
  assign fs_ext   = {{(tble_pkg::CoordW-tble_pkg::FontW){1'b0}}, geom_r.font_size};
  assign half_ext = {{(tble_pkg::CoordW-tble_pkg::FontW){1'b0}}, half_w};

  tble_place u_place (
    .geom     (geom_r),
    .cursor_x (cursor_x_r),
    .cursor_y (cursor_y_r),
    .glyph_w  (glyph_w),
    .place    (place)
  );

  // Byte decode; order of the tests decides, as a zero byte overrides all
  always_comb begin
    cursor_x_nxt     = cursor_x_r;
    cursor_y_nxt     = cursor_y_r;
    lead_byte_nxt    = lead_byte_r;
    lead_pending_nxt = lead_pending_r;
    skip_next_nxt    = skip_next_r;
    box_full_nxt     = box_full_r;
    emit             = 1'b0;
    emit_kind        = tble_pkg::KIND_HALF;
    emit_x           = place.x;
    emit_y           = place.y;
    emit_code        = {{(tble_pkg::CoordW-tble_pkg::ByteW){1'b0}}, in_byte_in};

    priority if (in_byte_in == tble_pkg::BYTE_END) begin
      // End of string: back to origin, drop all pending state
      cursor_x_nxt     = geom_r.origin_x;
      cursor_y_nxt     = geom_r.origin_y;
      lead_pending_nxt = 1'b0;
      skip_next_nxt    = 1'b0;
      box_full_nxt     = 1'b0;
      emit             = 1'b1;
      emit_kind        = tble_pkg::KIND_END;
      emit_x           = geom_r.origin_x;
      emit_y           = geom_r.origin_y;
      emit_code        = '0;
    end else if (box_full_r) begin
      // Box is full: ignore everything until the end of string
    end else if (skip_next_r) begin
      skip_next_nxt = 1'b0;
    end else if (lead_pending_r) begin
      // Trail byte completes a double-byte glyph
      lead_pending_nxt = 1'b0;
      cursor_x_nxt     = place.x;
      cursor_y_nxt     = place.y;
      emit             = 1'b1;
      emit_code        = {lead_byte_r, in_byte_in};
      if (place.full) begin
        box_full_nxt = 1'b1;
        emit_kind    = tble_pkg::KIND_FULL;
      end else begin
        emit_kind    = tble_pkg::KIND_DBL;
        cursor_x_nxt = place.x + fs_ext;
      end
    end else if (in_byte_in > tble_pkg::LEAD_MIN) begin
      // Hold the lead byte for its trail
      lead_byte_nxt    = in_byte_in;
      lead_pending_nxt = 1'b1;
    end else begin
      cursor_x_nxt = place.x;
      cursor_y_nxt = place.y;
      priority if (place.full) begin
        box_full_nxt = 1'b1;
        emit         = 1'b1;
        emit_kind    = tble_pkg::KIND_FULL;
      end else if (in_byte_in == tble_pkg::BYTE_CR) begin
        // New line; the byte after a carriage return is dropped unless it is a zero byte
        cursor_x_nxt  = geom_r.origin_x;
        cursor_y_nxt  = place.y + fs_ext;
        skip_next_nxt = 1'b1;
      end else begin
        emit         = 1'b1;
        emit_kind    = tble_pkg::KIND_HALF;
        cursor_x_nxt = place.x + half_ext;
      end
    end
  end

  // Configuration registers and layout state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      geom_r.origin_x   <= '0;
      geom_r.origin_y   <= '0;
      geom_r.box_width  <= tble_pkg::BOX_WIDTH_RST;
      geom_r.box_height <= tble_pkg::BOX_HEIGHT_RST;
      geom_r.font_size  <= tble_pkg::FONT_SIZE_RST;
      cursor_x_r        <= '0;
      cursor_y_r        <= '0;
      lead_byte_r       <= '0;
      lead_pending_r    <= 1'b0;
      skip_next_r       <= 1'b0;
      box_full_r        <= 1'b0;
    end else begin
      if (in_fire) begin
        cursor_x_r     <= cursor_x_nxt;
        cursor_y_r     <= cursor_y_nxt;
        lead_byte_r    <= lead_byte_nxt;
        lead_pending_r <= lead_pending_nxt;
        skip_next_r    <= skip_next_nxt;
        box_full_r     <= box_full_nxt;
      end
      // The user writes only while idle, unenforced; origin writes move the cursor
      if (cfg_fire) begin
        unique case (cfg_index)
          tble_pkg::REG_ORIGIN_X: begin
            geom_r.origin_x <= cfg_data;
            cursor_x_r      <= cfg_data;
          end
          tble_pkg::REG_ORIGIN_Y: begin
            geom_r.origin_y <= cfg_data;
            cursor_y_r      <= cfg_data;
          end
          tble_pkg::REG_BOX_WIDTH:  geom_r.box_width  <= cfg_data;
          tble_pkg::REG_BOX_HEIGHT: geom_r.box_height <= cfg_data;
          tble_pkg::REG_FONT_SIZE:  geom_r.font_size  <= cfg_data[tble_pkg::FontW-1:0];
          tble_pkg::REG_DRAW_MODE:  begin end
          tble_pkg::REG_TEXT_COLOR: begin end
          default: begin end
        endcase
      end
    end
  end

  // Result register: load on a command, drop once taken
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (in_fire && emit) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire && emit) begin
      out_kind_r <= emit_kind;
      out_x_r    <= emit_x;
      out_y_r    <= emit_y;
      out_code_r <= emit_code;
    end
  end

  assign out_valid      = out_valid_r;
  assign out_cmd_kind   = out_kind_r;
  assign out_glyph_x    = out_x_r;
  assign out_glyph_y    = out_y_r;
  assign out_glyph_code = out_code_r;

  // A zero byte always produces an end-of-string command next cycle
  a_end_emits: assert property (@(posedge clk) disable iff (!rst_n)
    (in_fire && in_byte_in == tble_pkg::BYTE_END)
      |=> (out_valid_r && out_kind_r == tble_pkg::KIND_END))
    else $error("end of string did not produce a command");

  // A box-full command leaves the block latched full
  a_full_latch: assert property (@(posedge clk) disable iff (!rst_n)
    (in_fire && emit && emit_kind == tble_pkg::KIND_FULL) |=> box_full_r)
    else $error("box-full command without full flag");

  // A full box never still holds a pending lead byte
  a_full_no_lead: assert property (@(posedge clk) disable iff (!rst_n)
    !(box_full_r && lead_pending_r))
    else $error("lead byte pending while box full");

  // Skip and lead pending exclude each other
  a_skip_no_lead: assert property (@(posedge clk) disable iff (!rst_n)
    !(skip_next_r && lead_pending_r))
    else $error("skip and lead pending together");

endmodule
